// ===== design/srx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package srx_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND = 2'd3;

  localparam logic       KIND_STATUS = 1'b0;
  localparam logic       KIND_REPLY  = 1'b1;
  localparam logic [7:0] CMD_SET_PIN = 8'd1;
  localparam logic [7:0] REPLY_ID    = 8'h00;
  localparam logic [7:0] PIN_ON_CODE = 8'd1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] SLOT_STATUS      = 3'd0;
  localparam logic [2:0] SLOT_HEAD_FIRST  = 3'd1;
  localparam logic [2:0] SLOT_HEAD_SECOND = 3'd2;
  localparam logic [2:0] SLOT_ID          = 3'd3;
  localparam logic [2:0] SLOT_DATA        = 3'd4;
  localparam logic [2:0] SLOT_SUM         = 3'd5;
  localparam logic [2:0] SLOT_TAIL_FIRST  = 3'd6;
  localparam logic [2:0] SLOT_TAIL_SECOND = 3'd7;

  typedef struct packed {
    logic [7:0] head_first;
    logic [7:0] head_second;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
  } cfg_t;

  typedef struct packed {
    logic       good;
    logic [7:0] command;
    logic       reply;
    logic [7:0] data;
    logic       pin;
  } job_t;

endpackage

// ===== design/srx_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_in_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface srx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/srx_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_out_if
// Result channel: frame status items and reply frame bytes.
// ----------------------------------------------------------------------------
interface srx_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       frame_good;
  logic [7:0] command;
  logic [7:0] reply_byte;
  logic       pin_level;
  logic       last;

  modport source (output valid, output kind, output frame_good, output command,
                  output reply_byte, output pin_level, output last, input ready);
  modport sink (input valid, input kind, input frame_good, input command,
                input reply_byte, input pin_level, input last, output ready);
endinterface

// ===== design/srx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_front
// Header/trailer detection, running checksum and frame close classification.
// ----------------------------------------------------------------------------
module srx_front #(
  parameter int MAX_STORED = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  srx_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          in_ready,
  output logic          push,
  output srx_pkg::job_t push_job,
  input  logic          queue_full
);
  import srx_pkg::*;

  localparam int CNT_W = $clog2(MAX_STORED + 1);

  logic             in_frame;
  logic [15:0]      head_window;
  logic [15:0]      tail_window;
  logic [CNT_W-1:0] stored_count;
  logic [7:0]       first_stored;
  logic [7:0]       second_stored;
  logic [7:0]       lagged_sum;
  logic [15:0]      recent_pair;
  logic             pin_state;

  logic             accept;
  logic [15:0]      head_next;
  logic [15:0]      tail_next;
  logic             head_hit;
  logic             tail_hit;
  logic             good;
  logic [7:0]       cmd;
  logic             reply;
  logic             pin_next;
  logic [CNT_W-1:0] count_inc;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign head_next = {head_window[7:0], in_byte};
  assign tail_next = {tail_window[7:0], in_byte};
  assign head_hit  = head_next == {cfg.head_first, cfg.head_second};
  assign tail_hit  = tail_next == {cfg.tail_first, cfg.tail_second};
  assign good      = (stored_count >= CNT_W'(2)) && (lagged_sum == recent_pair[15:8]);
  assign cmd       = (stored_count >= CNT_W'(1)) ? first_stored : 8'd0;
  assign reply     = good && (cmd == CMD_SET_PIN);
  assign pin_next  = reply ? (second_stored == PIN_ON_CODE) : pin_state;
  assign count_inc = stored_count + CNT_W'(1);

  assign push     = accept && in_frame && tail_hit;
  assign push_job = '{good: good, command: cmd, reply: reply, data: second_stored,
                      pin: pin_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      head_window  <= '0;
      tail_window  <= '0;
      stored_count <= '0;
      lagged_sum   <= '0;
      recent_pair  <= '0;
      pin_state    <= 1'b0;
    end else if (accept) begin
      if (!in_frame) begin
        head_window <= head_next;
        if (head_hit) begin
          in_frame     <= 1'b1;
          stored_count <= '0;
          lagged_sum   <= '0;
          recent_pair  <= '0;
        end
      end else begin
        tail_window <= tail_next;
        if (tail_hit) begin
          pin_state    <= pin_next;
          in_frame     <= 1'b0;
          stored_count <= '0;
        end else begin
          if (stored_count >= CNT_W'(2)) begin
            lagged_sum <= lagged_sum + recent_pair[15:8];
          end
          recent_pair <= {recent_pair[7:0], in_byte};
          if (count_inc >= CNT_W'(MAX_STORED)) begin
            stored_count <= '0;
            in_frame     <= 1'b0;
          end else begin
            stored_count <= count_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame && !tail_hit) begin
      if (stored_count == CNT_W'(0)) begin
        first_stored <= in_byte;
      end
      if (stored_count == CNT_W'(1)) begin
        second_stored <= in_byte;
      end
    end
  end

endmodule

// ===== design/srx_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_queue
// Short job queue between the frame front end and the result sequencer.
// ----------------------------------------------------------------------------
module srx_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srx_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output srx_pkg::job_t head_job
);
  import srx_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = fill == CNT_W'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign head_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fill <= fill + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("push into full queue");

endmodule

// ===== design/srx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_back
// Result sequencer: emits the status item and, for a set-pin command, the
// seven-byte reply frame.
// ----------------------------------------------------------------------------
module srx_back (
  input  logic          clk,
  input  logic          rst,
  input  srx_pkg::cfg_t cfg,
  input  logic          job_valid,
  input  srx_pkg::job_t job_in,
  output logic          pop,
  srx_out_if.source     tx
);
  import srx_pkg::*;

  job_t       job;
  logic       busy;
  logic [2:0] slot;
  logic       done;
  logic       final_item;

  assign final_item = !job.reply || (slot == SLOT_TAIL_SECOND);
  assign done       = tx.valid && tx.ready && final_item;
  assign pop        = job_valid && (!busy || done);

  assign tx.valid      = busy;
  assign tx.kind       = (slot == SLOT_STATUS) ? KIND_STATUS : KIND_REPLY;
  assign tx.frame_good = job.good;
  assign tx.command    = job.command;
  assign tx.pin_level  = job.pin;
  assign tx.last       = final_item;

  always_comb begin
    case (slot)
      SLOT_STATUS:      tx.reply_byte = 8'd0;
      SLOT_HEAD_FIRST:  tx.reply_byte = cfg.head_first;
      SLOT_HEAD_SECOND: tx.reply_byte = cfg.head_second;
      SLOT_ID:          tx.reply_byte = REPLY_ID;
      SLOT_DATA:        tx.reply_byte = job.data;
      SLOT_SUM:         tx.reply_byte = job.data;
      SLOT_TAIL_FIRST:  tx.reply_byte = cfg.tail_first;
      SLOT_TAIL_SECOND: tx.reply_byte = cfg.tail_second;
      default:          tx.reply_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SLOT_STATUS;
    end else if (pop) begin
      busy <= 1'b1;
      slot <= SLOT_STATUS;
    end else if (done) begin
      busy <= 1'b0;
      slot <= SLOT_STATUS;
    end else if (tx.valid && tx.ready) begin
      slot <= slot + 3'd1;
    end
  end

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    busy && !job.reply |-> slot == SLOT_STATUS)
    else $error("reply slot advanced for status-only job");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.ready && !tx.last |=> tx.valid && slot == $past(slot) + 3'd1)
    else $error("reply burst broken");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.kind == KIND_STATUS && !tx.frame_good |-> tx.last)
    else $error("bad frame status not final");

endmodule

// ===== design/serial_frame_receiver_with_reply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_with_reply
// Framed byte receiver with 8-bit sum check, status report and reply frame.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle unless the job queue is full; bytes that
// close no frame cause no result. A closing byte's job is queued, then loaded
// into the sequencer's job register, which presents its status item. Output
// runs one item per cycle while tx.ready is high: the status item, then seven
// reply bytes for a reply frame. A two-entry job queue absorbs close bursts.
// Synchronous reset clears frame state, pin and registers; no clearing pass.
module serial_frame_receiver_with_reply #(
  parameter int MAX_STORED = 50
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [srx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srx_pkg::CFG_DATA_W-1:0]   cfg_data,
  srx_in_if.sink                           rx,
  srx_out_if.source                        tx
);
  import srx_pkg::*;

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic queue_full;
  logic pop;
  logic job_valid;
  job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD_FIRST:  cfg.head_first  <= cfg_data;
        REG_HEAD_SECOND: cfg.head_second <= cfg_data;
        REG_TAIL_FIRST:  cfg.tail_first  <= cfg_data;
        REG_TAIL_SECOND: cfg.tail_second <= cfg_data;
        default:         cfg <= cfg;
      endcase
    end
  end

  srx_front #(.MAX_STORED(MAX_STORED)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (rx.valid),
    .in_byte    (rx.rx_byte),
    .in_ready   (rx.ready),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  srx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (job_valid),
    .head_job  (head_job)
  );

  srx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_in    (head_job),
    .pop       (pop),
    .tx        (tx)
  );

endmodule

// ===== tb/serial_frame_receiver_with_reply_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_with_reply_test
// Self-checking bench for the framed byte receiver with status and reply.
// A scripted opening covers the reset markers, command and pin replies,
// checksum extremes, short frames and trailer carry-over. Random frames follow
// under several marker settings. A byte-level tracker predicts every status
// item and reply byte, and each result is compared field by field.
// ----------------------------------------------------------------------------
module serial_frame_receiver_with_reply_test;
  import srx_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int MAX_STORED    = 50;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_BYTES   = 36;
  localparam int SCRIPT_LEN    = 32;
  localparam int REPLY_LEN     = 7;
  localparam int REPORT_CAP    = 30;

  typedef struct packed {
    logic       kind;
    logic       good;
    logic [7:0] command;
    logic [7:0] reply_byte;
    logic       pin;
    logic       last;
  } srx_item_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_CHECK, ROW_MARKERS} row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic [31:0] value;
    logic        exp_good;
    logic [7:0]  exp_cmd;
  } script_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_LONG} stall_mode_e;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srx_in_if  rx ();
  srx_out_if tx ();

  serial_frame_receiver_with_reply #(
    .MAX_STORED(MAX_STORED)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rx(rx),
    .tx(tx)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // tracker state
  cfg_t        markers;
  logic        fr_open;
  logic [15:0] head_win;
  logic [15:0] tail_win;
  logic [5:0]  stored_n;
  logic [7:0]  cmd_byte;
  logic [7:0]  data_byte;
  logic [7:0]  lag_sum;
  logic [15:0] last_two;
  logic        pin_now;

  srx_item_t   awaited_items [$];

  int          failures = 0;
  int          rx_bytes = 0;
  int          burst_left = 0;
  int          closed_frames = 0;
  int          good_frames = 0;
  int          results_seen = 0;
  int          reply_bytes = 0;
  int          marker_sets = 0;
  int          quiet_cycles = 0;

  stall_mode_e stall_mode;
  logic [6:0]  pace_cnt;
  logic [4:0]  hold_cnt;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_BYTE,    32'h0000_0000, 1'b0, 8'h00},
    '{ROW_CHECK,   32'h0000_0000, 1'b0, 8'h00},
    '{ROW_MARKERS, 32'hA55A_0D0A, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_00A5, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_005A, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_0001, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_0001, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_0002, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_000D, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_000A, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_00A5, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_005A, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_00FF, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_00FF, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_00FE, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_000D, 1'b0, 8'h00},
    '{ROW_CHECK,   32'h0000_000A, 1'b1, 8'hFF},
    '{ROW_BYTE,    32'h0000_00A5, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_005A, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_000D, 1'b0, 8'h00},
    '{ROW_CHECK,   32'h0000_000A, 1'b0, 8'h0D},
    '{ROW_MARKERS, 32'h00FF_0AFF, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_0000, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_00FF, 1'b0, 8'h00},
    '{ROW_CHECK,   32'h0000_00FF, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_0000, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_00FF, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_0001, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_0000, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_0001, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_000A, 1'b0, 8'h00},
    '{ROW_BYTE,    32'h0000_00FF, 1'b0, 8'h00}
  };

  task automatic track_rx_byte(input logic [7:0] b, output logic closed,
                               output srx_item_t status);
    logic       good;
    logic       reply;
    logic [7:0] cmd;
    logic [7:0] reply_seq [REPLY_LEN];
    srx_item_t  item;
    closed = 1'b0;
    status = '0;
    if (!fr_open) begin
      head_win = {head_win[7:0], b};
      if (head_win == {markers.head_first, markers.head_second}) begin
        fr_open = 1'b1;
        stored_n = '0;
        lag_sum = '0;
        last_two = '0;
      end
    end else begin
      tail_win = {tail_win[7:0], b};
      if (tail_win == {markers.tail_first, markers.tail_second}) begin
        good = (stored_n >= 6'd2) && (lag_sum == last_two[15:8]);
        cmd = (stored_n >= 6'd1) ? cmd_byte : 8'h00;
        reply = good && (cmd == CMD_SET_PIN);
        if (reply) pin_now = (data_byte == PIN_ON_CODE);
        status.kind = KIND_STATUS;
        status.good = good;
        status.command = cmd;
        status.reply_byte = 8'h00;
        status.pin = pin_now;
        status.last = !reply;
        awaited_items.push_back(status);
        if (reply) begin
          reply_seq = '{markers.head_first, markers.head_second, REPLY_ID, data_byte,
                        data_byte, markers.tail_first, markers.tail_second};
          for (int i = 0; i < REPLY_LEN; i++) begin
            item.kind = KIND_REPLY;
            item.good = 1'b1;
            item.command = cmd;
            item.reply_byte = reply_seq[i];
            item.pin = pin_now;
            item.last = (i == REPLY_LEN - 1);
            awaited_items.push_back(item);
          end
        end
        closed = 1'b1;
        fr_open = 1'b0;
        stored_n = '0;
      end else begin
        if (stored_n == 6'd0) cmd_byte = b;
        else if (stored_n == 6'd1) data_byte = b;
        if (stored_n >= 6'd2) lag_sum = lag_sum + last_two[15:8];
        last_two = {last_two[7:0], b};
        stored_n = stored_n + 1'b1;
        if (stored_n >= 6'(MAX_STORED)) begin
          stored_n = '0;
          fr_open = 1'b0;
        end
      end
    end
  endtask

  // hold valid across a burst; drop it only for a gap
  task automatic push_byte(input logic [7:0] b, output logic closed,
                           output srx_item_t status);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        rx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    burst_left--;
    rx_bytes++;
    track_rx_byte(b, closed, status);
  endtask

  task automatic settle();
    rx.valid <= 1'b0;
    while (awaited_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_markers(input cfg_t m);
    cfg_we <= 1'b1;
    cfg_index <= REG_HEAD_FIRST;
    cfg_data <= m.head_first;
    @(posedge clk);
    cfg_index <= REG_HEAD_SECOND;
    cfg_data <= m.head_second;
    @(posedge clk);
    cfg_index <= REG_TAIL_FIRST;
    cfg_data <= m.tail_first;
    @(posedge clk);
    cfg_index <= REG_TAIL_SECOND;
    cfg_data <= m.tail_second;
    @(posedge clk);
    cfg_we <= 1'b0;
    markers = m;
    marker_sets++;
  endtask

  task automatic send_random_frame();
    logic [7:0] body [$];
    logic [7:0] payload;
    logic [7:0] sum;
    logic       closed;
    srx_item_t  status;
    int         pick;
    int         n;
    pick = $urandom_range(0, 99);
    body = {};
    if (pick >= 8) begin
      body.push_back(markers.head_first);
      body.push_back(markers.head_second);
    end
    if (pick < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) body.push_back(8'($urandom()));
    end else if (pick < 11) begin
      repeat (MAX_STORED) body.push_back(8'($urandom()));
    end else if (pick < 20) begin
      if (pick[0]) body.push_back(8'($urandom()));
      body.push_back(markers.tail_first);
      body.push_back(markers.tail_second);
    end else begin
      n = $urandom_range(2, 6);
      sum = '0;
      for (int i = 0; i < n; i++) begin
        if (i == 0) payload = (pick < 75) ? CMD_SET_PIN : 8'($urandom());
        else if (i == 1 && pick[1]) payload = PIN_ON_CODE;
        else payload = 8'($urandom());
        sum = sum + payload;
        body.push_back(payload);
      end
      if (pick < 30) sum = sum ^ 8'($urandom_range(1, 255));
      body.push_back(sum);
      body.push_back(markers.tail_first);
      body.push_back(markers.tail_second);
    end
    foreach (body[i]) begin
      push_byte(body[i], closed, status);
      if (closed) begin
        closed_frames++;
        if (status.good) good_frames++;
      end
    end
  endtask

  function automatic void report(input string field, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
    failures++;
    if (failures <= REPORT_CAP)
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want_v, got_v);
  endfunction

  task automatic check_result();
    srx_item_t got;
    srx_item_t want;
    got = {tx.kind, tx.frame_good, tx.command, tx.reply_byte, tx.pin_level, tx.last};
    results_seen++;
    if (got.kind == KIND_REPLY) reply_bytes++;
    if (awaited_items.size() == 0) begin
      failures++;
      if (failures <= REPORT_CAP)
        $display("%0t: unexpected result, expected none, actual kind=%0d command=%02h byte=%02h",
                 $time, got.kind, got.command, got.reply_byte);
    end else begin
      want = awaited_items.pop_front();
      if (got.kind != want.kind) report("kind", 8'(want.kind), 8'(got.kind));
      if (got.good != want.good) report("frame_good", 8'(want.good), 8'(got.good));
      if (got.command != want.command) report("command", want.command, got.command);
      if (got.reply_byte != want.reply_byte)
        report("reply_byte", want.reply_byte, got.reply_byte);
      if (got.pin != want.pin) report("pin_level", 8'(want.pin), 8'(got.pin));
      if (got.last != want.last) report("last", 8'(want.last), 8'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tx.ready <= 1'b0;
      stall_mode <= STALL_NONE;
      pace_cnt <= '0;
      hold_cnt <= '0;
    end else begin
      if (tx.valid && tx.ready) check_result();
      pace_cnt <= pace_cnt + 1'b1;
      if (pace_cnt == '0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE: tx.ready <= 1'b1;
        STALL_COIN: tx.ready <= 1'($urandom_range(0, 1));
        STALL_SPARSE: tx.ready <= (pace_cnt[1:0] == 2'd0);
        STALL_LONG: begin
          if (hold_cnt != '0) begin
            tx.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1'b1;
          end else if ($urandom_range(0, 11) == 0) begin
            tx.ready <= 1'b0;
            hold_cnt <= 5'($urandom_range(4, 24));
          end else begin
            tx.ready <= 1'b1;
          end
        end
        default: tx.ready <= 1'b1;
      endcase
    end
  end

  // count cycles without a single transaction
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (tx.valid && tx.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    script_row_t row;
    logic        closed;
    srx_item_t   status;
    cfg_t        m;
    int          phase_start;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_HEAD_FIRST;
    cfg_data <= '0;
    rx.valid <= 1'b0;
    rx.rx_byte <= '0;
    markers = '0;
    fr_open = 1'b0;
    head_win = '0;
    tail_win = '0;
    stored_n = '0;
    cmd_byte = '0;
    data_byte = '0;
    lag_sum = '0;
    last_two = '0;
    pin_now = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      row = script[r];
      if (row.op == ROW_MARKERS) begin
        settle();
        load_markers(cfg_t'(row.value));
      end else begin
        push_byte(row.value[7:0], closed, status);
        if (row.op == ROW_CHECK &&
            (!closed || status.good != row.exp_good || status.command != row.exp_cmd)) begin
          failures++;
          $display("%0t: row %0d want good=%0d cmd=%02h, got closed=%0d good=%0d cmd=%02h",
                   $time, r, row.exp_good, row.exp_cmd, closed, status.good, status.command);
        end
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      if (ph == 0) m = '1;
      else if (ph == 1) m = '0;
      else m = cfg_t'($urandom());
      load_markers(m);
      phase_start = rx_bytes;
      while (rx_bytes - phase_start < PHASE_BYTES) send_random_frame();
    end
    settle();

    $display("Sent %0d bytes under %0d marker settings: %0d frames closed, %0d with good sum.",
             rx_bytes, marker_sets, closed_frames, good_frames);
    $display("Checked %0d result transactions, %0d of them reply bytes.",
             results_seen, reply_bytes);
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/srx_pkg.sv
design/srx_in_if.sv
design/srx_out_if.sv
design/srx_front.sv
design/srx_queue.sv
design/srx_back.sv
design/serial_frame_receiver_with_reply.sv
tb/serial_frame_receiver_with_reply_test.sv
